[design/ssm_pkg.sv]
// shared types and constants for the stream substring match unit
// no dependencies
`default_nettype none

package ssm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int WORD_BYTES  = CFG_DATA_W / BYTE_W;
  localparam int PAT_WORDS   = 4;
  localparam int PAT_STORED  = PAT_WORDS * WORD_BYTES;
  localparam int CELL_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD0  = 3'd1,
    REG_PATTERN_WORD1  = 3'd2,
    REG_PATTERN_WORD2  = 3'd3,
    REG_PATTERN_WORD3  = 3'd4
  } cfg_reg_t;

  typedef logic [PAT_STORED-1:0][BYTE_W-1:0] pat_bytes_t;

  typedef struct packed {
    logic accept;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/ssm_cell.sv]
// one window cell: holds one text byte and its valid flag, hands both to its
// right neighbour on every accepted byte and compares the incoming byte
// against the pattern byte aligned to its place; uses ssm_pkg
`default_nettype none

module ssm_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ssm_pkg::cell_ctrl_t        ctrl,
  input  wire logic [ssm_pkg::BYTE_W-1:0] prev_byte,
  input  wire logic                       prev_valid,
  input  wire logic [ssm_pkg::BYTE_W-1:0] pat_byte,
  output logic                            hit_nxt,
  output logic [ssm_pkg::BYTE_W-1:0]      byte_r,
  output logic                            valid_r
);
  import ssm_pkg::*;

  assign hit_nxt = prev_valid && (prev_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r  <= '0;
      valid_r <= 1'b0;
    end else if (ctrl.accept) begin
      byte_r  <= prev_byte;
      valid_r <= ctrl.clear ? 1'b0 : prev_valid;
    end
  end

endmodule

`default_nettype wire

[design/ssm_cfg.sv]
// pattern length and pattern byte registers behind the write port
// uses ssm_pkg
`default_nettype none

module ssm_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic      [ssm_pkg::LEN_W-1:0]      len_eff,
  output ssm_pkg::pat_bytes_t                 pat_bytes
);
  import ssm_pkg::*;

  logic [LEN_W-1:0]                      len_r;
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]  pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pat_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: len_r    <= cfg_data[LEN_W-1:0];
        REG_PATTERN_WORD0:  pat_r[0] <= cfg_data;
        REG_PATTERN_WORD1:  pat_r[1] <= cfg_data;
        REG_PATTERN_WORD2:  pat_r[2] <= cfg_data;
        REG_PATTERN_WORD3:  pat_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  localparam int LEN_CAP = (PATTERN_MAX < PAT_STORED) ? PATTERN_MAX : PAT_STORED;

  always_comb begin
    if (len_r > LEN_W'(LEN_CAP)) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = len_r;
    end
  end

  assign pat_bytes = pat_r;

endmodule

`default_nettype wire

[design/stream_substring_match_unit.sv]
// Streaming exact substring search. Text bytes enter one per transfer on
// in_tdata with in_tlast on the last byte of a text; each byte gives one
// result transfer with match_here, found and text_done (out_tlast). A row of
// window cells holds the most recent bytes of the current text with a valid
// flag each; every cell compares the byte it is about to take against the
// pattern byte aligned to its place, all at once, so one byte is taken in
// every cycle; the result sits in a single output register, and a byte is
// taken while that register is empty or being drained. Found and the cell
// flags clear after the byte marked last; pattern writes take effect from
// the next byte on.
// depends on ssm_pkg, ssm_cell and ssm_cfg
`default_nettype none

module stream_substring_match_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ssm_pkg::BYTE_W-1:0]     in_tdata,   // text_byte
  input  wire logic                           in_tlast,   // end_of_text
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [ssm_pkg::OUT_DATA_W-1:0]      out_tdata,  // match_here, found, zero fill
  output logic                                out_tlast   // text_done
);
  import ssm_pkg::*;

  logic [LEN_W-1:0]                    len_eff;
  pat_bytes_t                          pat_bytes;
  cell_ctrl_t                          ctrl;
  logic [PATTERN_MAX-1:0]              hit_nxt;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0]  window_r;
  logic [PATTERN_MAX-1:0]              valid_r;
  logic [PATTERN_MAX-1:0]              active;
  logic                                in_accept;
  logic                                first_r;
  logic                                found_r;
  logic                                found_nxt;
  logic                                match;
  logic                                out_valid_r;
  logic                                match_out_r;
  logic                                found_out_r;
  logic                                last_out_r;

  ssm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .len_eff   (len_eff),
    .pat_bytes (pat_bytes)
  );

  assign in_tready    = !out_valid_r || out_tready;
  assign in_accept    = in_tvalid && in_tready;
  assign ctrl.accept  = in_accept;
  assign ctrl.clear   = in_tlast;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [BYTE_W-1:0]     prev_byte;
    logic                  prev_valid;
    logic [CELL_IDX_W-1:0] pat_idx;
    if (k == 0) begin : g_head
      assign prev_byte  = in_tdata;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_byte  = window_r[k-1];
      assign prev_valid = valid_r[k-1];
    end
    // newest byte lines up with the last pattern byte
    assign pat_idx   = CELL_IDX_W'(len_eff - LEN_W'(k + 1));
    assign active[k] = (LEN_W'(k) < len_eff);
    ssm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_byte  (prev_byte),
      .prev_valid (prev_valid),
      .pat_byte   (pat_bytes[pat_idx]),
      .hit_nxt    (hit_nxt[k]),
      .byte_r     (window_r[k]),
      .valid_r    (valid_r[k])
    );
  end

  always_comb begin
    if (len_eff == '0) begin
      match = first_r;
    end else begin
      match = &(hit_nxt | ~active);
    end
    found_nxt = found_r || match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      found_r <= 1'b0;
    end else if (in_accept) begin
      first_r <= in_tlast;
      found_r <= in_tlast ? 1'b0 : found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      match_out_r <= match;
      found_out_r <= found_nxt;
      last_out_r  <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, found_out_r, match_out_r};
  assign out_tlast  = last_out_r;

  a_match_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || out_tdata[1]))
    else $error("match without found");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tlast) |=> (!found_r && first_r && (valid_r == '0)))
    else $error("state not cleared after last byte");

  a_valid_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_accept))
    else $error("result without transfer");

  a_first_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_tlast) |=> !first_r)
    else $error("first byte flag stuck");

  a_window_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (window_r == {$past(window_r[PATTERN_MAX-2:0]), $past(in_tdata)}))
    else $error("window did not shift");

endmodule

`default_nettype wire
